@@ hdl/irac_pkg.sv @@
// Shared types, constants and symbol tables of the IR air conditioner frame sender.
package irac_pkg;

    // Frame geometry and temperature range
    localparam logic [7:0] FRAME_SYMBOLS = 8'd199;
    localparam logic [7:0] WORD_LEN      = 8'd99;
    localparam logic [4:0] MIN_TEMP      = 5'd17;
    localparam logic [4:0] MAX_TEMP      = 5'd30;
    localparam logic [3:0] NUM_TEMPS     = 4'd14;

    // Symbol kinds, each with a programmable length
    typedef enum logic [1:0] {
        SYM_GAP   = 2'd0,
        SYM_HEAD  = 2'd1,
        SYM_LONG  = 2'd2,
        SYM_SHORT = 2'd3
    } sym_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_GAP    = 2'd0,
        REG_HEADER = 2'd1,
        REG_LONG   = 2'd2,
        REG_SHORT  = 2'd3
    } cfg_addr_t;

    // Programmed symbol lengths in microseconds
    typedef struct packed {
        logic [15:0] gap;
        logic [15:0] header;
        logic [15:0] long_len;
        logic [15:0] short_len;
    } durations_t;

    // Symbol lookup result
    typedef struct packed {
        logic        at_end;
        logic [15:0] duration;
    } decode_t;

    // First temperature slot: bit j set means symbol j of the slot is long
    function automatic logic [6:0] first_slot(logic [3:0] t);
        logic [6:0] bits;
        case (t)
            4'd1:    bits = 7'b1000000;
            4'd2:    bits = 7'b1010000;
            4'd3:    bits = 7'b0010000;
            4'd4:    bits = 7'b0010100;
            4'd5:    bits = 7'b1010100;
            4'd6:    bits = 7'b1000100;
            4'd7:    bits = 7'b0000100;
            4'd8:    bits = 7'b0000101;
            4'd9:    bits = 7'b1000101;
            4'd10:   bits = 7'b1000001;
            4'd11:   bits = 7'b0000001;
            4'd12:   bits = 7'b0010001;
            4'd13:   bits = 7'b1010001;
            default: bits = 7'b0000000;
        endcase
        return bits;
    endfunction

    // Second temperature slot, same coding
    function automatic logic [6:0] second_slot(logic [3:0] t);
        logic [6:0] bits;
        case (t)
            4'd1:    bits = 7'b0010101;
            4'd2:    bits = 7'b0000101;
            4'd3:    bits = 7'b1000101;
            4'd4:    bits = 7'b1000001;
            4'd5:    bits = 7'b0000001;
            4'd6:    bits = 7'b0010001;
            4'd7:    bits = 7'b1010001;
            4'd8:    bits = 7'b1010000;
            4'd9:    bits = 7'b0010000;
            4'd10:   bits = 7'b0010100;
            4'd11:   bits = 7'b1010100;
            4'd12:   bits = 7'b1000100;
            4'd13:   bits = 7'b0000100;
            default: bits = 7'b1010101;
        endcase
        return bits;
    endfunction

    // Symbol k of the 99-symbol word
    function automatic sym_t word_symbol(logic [6:0] k, logic off, logic [3:0] t);
        logic [6:0] first_bits;
        logic [6:0] second_bits;
        logic [6:0] rel_first;
        logic [6:0] rel_second;
        logic       is_long;
        sym_t       s;
        first_bits  = first_slot(t);
        second_bits = second_slot(t);
        rel_first   = k - 7'd67;
        rel_second  = k - 7'd83;
        is_long     = 1'b0;
        if (k < 7'd35) begin
            case (k) inside
                7'd3, 7'd7, 7'd9, 7'd15, 7'd21, 7'd27, 7'd29, 7'd33: is_long = 1'b1;
                default: is_long = 1'b0;
            endcase
        end
        else if (k < 7'd40) begin
            is_long = off ? (k == 7'd37 || k == 7'd39) : (k == 7'd35 || k == 7'd39);
        end
        else if (k < 7'd45) begin
            is_long = (k == 7'd41 || k == 7'd43);
        end
        else if (k < 7'd54) begin
            is_long = off ? (k == 7'd47 || k == 7'd49 || k == 7'd51)
                          : (k == 7'd45 || k == 7'd47 || k == 7'd49 || k == 7'd53);
        end
        else if (k < 7'd60) begin
            is_long = 1'b0;
        end
        else if (k < 7'd74) begin
            if (off) begin
                is_long = (k == 7'd61 || k == 7'd67 || k == 7'd69 || k == 7'd71);
            end
            else begin
                is_long = (k >= 7'd67) ? first_bits[rel_first[2:0]] : 1'b0;
            end
        end
        else if (k < 7'd83) begin
            is_long = 1'b0;
        end
        else if (k < 7'd90) begin
            is_long = off ? (k == 7'd89) : second_bits[rel_second[2:0]];
        end
        else if (k < 7'd99) begin
            // tail alternates short and long
            is_long = k[0];
        end
        if (k < 7'd2) begin
            s = SYM_HEAD;
        end
        else begin
            s = is_long ? SYM_LONG : SYM_SHORT;
        end
        return s;
    endfunction

endpackage

@@ hdl/irac_symbol_decode.sv @@
// Symbol lookup: frame position to symbol length, with end-of-frame flag.
module irac_symbol_decode (
    input  logic [7:0]           position,
    input  logic                 frame_off,
    input  logic [3:0]           temp_index,
    input  irac_pkg::durations_t durations,
    output irac_pkg::decode_t    result
);

    irac_pkg::sym_t kind;
    logic [7:0]     second_pos;

    // Map the frame position onto the word or the gap
    always_comb
    begin
        second_pos = position - (irac_pkg::WORD_LEN + 8'd1);
        if (position < irac_pkg::WORD_LEN) begin
            kind = irac_pkg::word_symbol(position[6:0], frame_off, temp_index);
        end
        else if (position == irac_pkg::WORD_LEN) begin
            kind = irac_pkg::SYM_GAP;
        end
        else begin
            kind = irac_pkg::word_symbol(second_pos[6:0], frame_off, temp_index);
        end
    end

    // Pick the programmed length for the symbol kind
    always_comb
    begin
        result.at_end = (position >= irac_pkg::FRAME_SYMBOLS);
        unique case (kind)
            irac_pkg::SYM_GAP:   result.duration = durations.gap;
            irac_pkg::SYM_HEAD:  result.duration = durations.header;
            irac_pkg::SYM_LONG:  result.duration = durations.long_len;
            irac_pkg::SYM_SHORT: result.duration = durations.short_len;
            default:             result.duration = durations.short_len;
        endcase
    end

endmodule

@@ hdl/ir_aircon_frame_sender_top.sv @@
// Top level of the IR air conditioner frame sender: command, timing and result register.
//
// Each input transfer (a 1 us tick or a send command) gives one registered result transfer,
// and a new item is taken every cycle while the result register drains and no skip runs. A
// command for 17..30 degrees or off, taken while idle, starts a 199-symbol frame; ticks
// count the current symbol down and step to the next. Symbols programmed to zero length are
// skipped by a sequencer that advances one frame position per cycle, holding s_tready low
// meanwhile. Configuration writes are accepted every cycle and affect symbols loaded
// afterwards.
module ir_aircon_frame_sender_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // temperature[6:0], emitter[7], unit_running[8], zeros
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // carrier_enable_a[0], carrier_enable_b[1], busy_res[2],
                                   // command_accepted[3], reported_setting[9:4], zeros
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    irac_pkg::durations_t durations_reg;
    irac_pkg::decode_t    dec;

    logic             sending_reg, sending_next;
    logic [7:0]       pos_reg, pos_next;
    logic [15:0]      time_left_reg, time_left_next;
    logic             off_reg, off_next;
    logic [3:0]       tidx_reg, tidx_next;
    logic             emit_reg, emit_next;
    logic [1:0][4:0]  stored_reg, stored_next;
    logic             pend_reg, pend_next;
    logic             pend_unit_reg, pend_unit_next;
    logic             pend_run_reg, pend_run_next;
    logic             pend_acc_reg, pend_acc_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [15:0]      m_tdata_reg, m_tdata_next;

    logic             in_fire;
    logic [6:0]       in_temp;
    logic             temp_ok;
    logic             cmd_start;
    logic             tick_count;
    logic             load_req;
    logic [7:0]       load_pos;
    logic             skip;
    logic             result_done;
    logic             cur_unit, cur_run, cur_acc;
    logic             mark;
    logic [4:0]       setting;
    logic [4:0]       unit_setting;
    logic [5:0]       rep;

    assign cfg_ready = 1'b1;
    assign s_tready  = !pend_reg && (!m_tvalid_reg || m_tready);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign in_temp   = s_tdata[6:0];
    assign temp_ok   = (in_temp == 7'd0) ||
                       (in_temp >= 7'(irac_pkg::MIN_TEMP) && in_temp <= 7'(irac_pkg::MAX_TEMP));

    // Look up the symbol being loaded
    irac_symbol_decode u_decode (
        .position   (load_pos),
        .frame_off  (off_next),
        .temp_index (tidx_next),
        .durations  (durations_reg),
        .result     (dec)
    );

    // Hold the programmed lengths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            durations_reg.gap       <= 16'd5300;
            durations_reg.header    <= 16'd4400;
            durations_reg.long_len  <= 16'd1660;
            durations_reg.short_len <= 16'd550;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (irac_pkg::cfg_addr_t'(cfg_addr))
                irac_pkg::REG_GAP:    durations_reg.gap       <= cfg_data;
                irac_pkg::REG_HEADER: durations_reg.header    <= cfg_data;
                irac_pkg::REG_LONG:   durations_reg.long_len  <= cfg_data;
                irac_pkg::REG_SHORT:  durations_reg.short_len <= cfg_data;
                default:              durations_reg.gap       <= durations_reg.gap;
            endcase
        end
    end

    // Take a command or a tick and pick the frame position to load
    always_comb
    begin
        off_next       = off_reg;
        tidx_next      = tidx_reg;
        emit_next      = emit_reg;
        pend_unit_next = pend_unit_reg;
        pend_run_next  = pend_run_reg;
        pend_acc_next  = pend_acc_reg;
        cmd_start      = 1'b0;
        tick_count     = 1'b0;
        load_req       = 1'b0;
        load_pos       = pos_reg;

        if (pend_reg) begin
            // carry on skipping zero-length symbols
            load_req = 1'b1;
        end
        else if (in_fire) begin
            pend_unit_next = s_tdata[7];
            pend_run_next  = s_tdata[8];
            pend_acc_next  = 1'b0;
            if (s_tuser) begin
                if (!sending_reg && temp_ok) begin
                    pend_acc_next = 1'b1;
                    cmd_start     = 1'b1;
                    off_next      = (in_temp == 7'd0);
                    tidx_next     = (in_temp == 7'd0) ? 4'd0
                                    : 4'(in_temp - 7'(irac_pkg::MIN_TEMP));
                    emit_next     = s_tdata[7];
                    load_req      = 1'b1;
                    load_pos      = 8'd0;
                end
            end
            else if (sending_reg) begin
                if (time_left_reg > 16'd1) begin
                    tick_count = 1'b1;
                end
                else begin
                    load_req = 1'b1;
                    load_pos = pos_reg + 8'd1;
                end
            end
        end
    end

    // Load the symbol, skip a zero length or close the frame
    always_comb
    begin
        sending_next   = sending_reg || cmd_start;
        pos_next       = pos_reg;
        time_left_next = tick_count ? (time_left_reg - 16'd1) : time_left_reg;
        stored_next    = stored_reg;
        skip           = 1'b0;

        setting = off_next ? 5'd0 : 5'(tidx_next + 4'(0)) + irac_pkg::MIN_TEMP;

        if (load_req) begin
            if (dec.at_end) begin
                // frame complete: record the unit's setting
                sending_next           = 1'b0;
                time_left_next         = 16'd0;
                pos_next               = load_pos;
                stored_next[emit_next] = setting;
            end
            else if (dec.duration != 16'd0) begin
                pos_next       = load_pos;
                time_left_next = dec.duration;
            end
            else begin
                pos_next = load_pos + 8'd1;
                skip     = 1'b1;
            end
        end
    end

    assign pend_next   = skip;
    assign result_done = (in_fire || pend_reg) && !skip;

    // Build the result from the updated state
    always_comb
    begin
        cur_unit     = pend_reg ? pend_unit_reg : s_tdata[7];
        cur_run      = pend_reg ? pend_run_reg  : s_tdata[8];
        cur_acc      = pend_acc_next;
        mark         = sending_next && !pos_next[0];
        unit_setting = stored_next[cur_unit];
        if (!cur_run) begin
            rep = 6'd0;
        end
        else if (unit_setting != 5'd0) begin
            rep = {1'b0, unit_setting};
        end
        else begin
            rep = 6'h3F;
        end
        m_tdata_next = {6'd0, rep, cur_acc, sending_next,
                        mark && emit_next, mark && !emit_next};
        if (result_done) begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Advance the frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sending_reg   <= 1'b0;
            pos_reg       <= 8'd0;
            time_left_reg <= 16'd0;
            off_reg       <= 1'b0;
            tidx_reg      <= 4'd0;
            emit_reg      <= 1'b0;
            stored_reg    <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else begin
            sending_reg   <= sending_next;
            pos_reg       <= pos_next;
            time_left_reg <= time_left_next;
            off_reg       <= off_next;
            tidx_reg      <= tidx_next;
            emit_reg      <= emit_next;
            stored_reg    <= stored_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Hold the item fields and the result payload
    always_ff @(posedge clk)
    begin
        pend_unit_reg <= pend_unit_next;
        pend_run_reg  <= pend_run_next;
        pend_acc_reg  <= pend_acc_next;
        if (result_done) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // A skip sequence only runs while the result register is empty
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |-> !m_tvalid_reg)
        else $error("skip sequence running with a result waiting");

    // An idle sender has no symbol time left
    assert property (@(posedge clk) disable iff (!rst_n) !sending_reg |-> time_left_reg == 16'd0)
        else $error("time left while idle");

    // A loaded symbol always lies inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (sending_reg && !pend_reg) |-> (pos_reg < irac_pkg::FRAME_SYMBOLS))
        else $error("symbol position past the frame");

    // Only one emitter drives its carrier at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("both carriers enabled");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the IR air conditioner frame sender top level.
`timescale 1ns / 100ps

module tb_top;

    // Item kinds carried in s_tuser
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SEND = 1'b1;

    // Register indexes
    localparam irac_pkg::cfg_addr_t CFG_GAP    = irac_pkg::REG_GAP;
    localparam irac_pkg::cfg_addr_t CFG_HEADER = irac_pkg::REG_HEADER;
    localparam irac_pkg::cfg_addr_t CFG_LONG   = irac_pkg::REG_LONG;
    localparam irac_pkg::cfg_addr_t CFG_SHORT  = irac_pkg::REG_SHORT;

    // Reported setting codes
    localparam logic signed [5:0] SET_OFF     = 6'sd0;
    localparam logic signed [5:0] SET_UNKNOWN = -6'sd1;

    // Symbol letters of the frame tables
    localparam byte L_GAP   = "A";
    localparam byte L_HEAD  = "B";
    localparam byte L_LONG  = "C";
    localparam byte L_SHORT = "D";

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int DIR_ROWS        = 28;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic                mark_a;
        logic                mark_b;
        logic                busy;
        logic                accepted;
        logic signed [5:0]   setting;
    } report_t;

    typedef struct packed {
        row_kind_t           kind;
        logic                act;
        logic [6:0]          temp;
        logic                em;
        logic                run;
        irac_pkg::cfg_addr_t addr;
        logic [15:0]         val;
        logic                typed;
        logic                w_busy;
        logic                w_acc;
        logic signed [5:0]   w_set;
    } row_t;

    typedef struct packed {
        logic                typed;
        report_t             want;
    } fixed_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // temperature[6:0], emitter[7], unit_running[8], zeros
    logic        s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // carrier_enable_a[0], carrier_enable_b[1], busy_res[2],
                            // command_accepted[3], reported_setting[9:4], zeros
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_data;

    // Frame word segments
    string seq_head  = "BBDCDDDCDCDDDDDCDDDDDCDDDDDCDCDDDCD";
    string seq_b_on  = "CDDDC";
    string seq_b_off = "DDCDC";
    string seq_c     = "DCDCD";
    string seq_d_on  = "CDCDCDDDC";
    string seq_d_off = "DDCDCDCDD";
    string seq_e_off = "DCDDDDDCDCDCDD";
    string seq_f_off = "DDDDDDC";
    string seq_tail  = "DCDCDCDCD";

    // Frame player state mirrored from the block
    logic [15:0] sym_len [4];
    logic        p_sending;
    logic [7:0]  p_pos;
    logic [15:0] p_left;
    logic        p_off;
    logic [3:0]  p_tidx;
    logic        p_emit;
    logic [4:0]  p_stored [2];

    report_t     due_reports [$];
    fixed_t      fixed_reports [$];
    report_t     got_rep;
    report_t     want_rep;
    report_t     pred_rep;
    fixed_t      fx_rep;

    int          n_sent;
    int          n_recv;
    int          n_errors;
    int          n_started;
    int          n_frames;
    int          n_cfg;
    int          burst_left;
    bit          tx_steady;
    logic [15:0] rx_pattern;
    logic [3:0]  rx_tick;

    row_t dir_table [DIR_ROWS] = '{
        // idle block after reset, rejected temperatures
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b1, 1'b1, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b0, SET_UNKNOWN},
        '{ROW_ITEM, ACT_SEND, 7'd31,  1'b0, 1'b1, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b0, SET_UNKNOWN},
        '{ROW_ITEM, ACT_SEND, 7'd127, 1'b1, 1'b0, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_SEND, 7'd16,  1'b0, 1'b1, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b0, SET_UNKNOWN},
        // every symbol zero length: each frame completes within its command
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_HEADER, 16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_LONG,   16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_SHORT,  16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_SEND, 7'd17,  1'b0, 1'b1, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b1, 6'sd17},
        '{ROW_ITEM, ACT_SEND, 7'd30,  1'b1, 1'b1, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b1, 6'sd30},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b1, 1'b0, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b1, 1'b1, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b0, 6'sd30},
        '{ROW_ITEM, ACT_SEND, 7'd0,   1'b0, 1'b1, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b1, SET_UNKNOWN},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_GAP,    16'd0, 1'b1, 1'b0, 1'b0, SET_OFF},
        // short real frame, command while busy, length change mid-frame
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_GAP,    16'd3, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_HEADER, 16'd2, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_LONG,   16'd2, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_SHORT,  16'd1, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_SEND, 7'd23,  1'b1, 1'b1, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_SEND, 7'd25,  1'b0, 1'b1, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b1, 1'b1, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b1, 1'b1, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b0, 1'b1, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_CFG,  ACT_TICK, 7'd0,   1'b0, 1'b0, CFG_LONG,   16'd4, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b1, 1'b0, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_TICK, 7'd0,   1'b0, 1'b1, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF},
        '{ROW_ITEM, ACT_SEND, 7'd0,   1'b1, 1'b0, CFG_GAP,    16'd0, 1'b0, 1'b0, 1'b0, SET_OFF}
    };

    ir_aircon_frame_sender_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // First temperature slot of the word, per temperature index
    function automatic string first_slot_seq(input logic [3:0] t);
        case (t)
            4'd0:    return "DDDDDDD";
            4'd1:    return "DDDDDDC";
            4'd2:    return "DDDDCDC";
            4'd3:    return "DDDDCDD";
            4'd4:    return "DDCDCDD";
            4'd5:    return "DDCDCDC";
            4'd6:    return "DDCDDDC";
            4'd7:    return "DDCDDDD";
            4'd8:    return "CDCDDDD";
            4'd9:    return "CDCDDDC";
            4'd10:   return "CDDDDDC";
            4'd11:   return "CDDDDDD";
            4'd12:   return "CDDDCDD";
            default: return "CDDDCDC";
        endcase
    endfunction

    // Second temperature slot of the word
    function automatic string second_slot_seq(input logic [3:0] t);
        case (t)
            4'd0:    return "CDCDCDC";
            4'd1:    return "CDCDCDD";
            4'd2:    return "CDCDDDD";
            4'd3:    return "CDCDDDC";
            4'd4:    return "CDDDDDC";
            4'd5:    return "CDDDDDD";
            4'd6:    return "CDDDCDD";
            4'd7:    return "CDDDCDC";
            4'd8:    return "DDDDCDC";
            4'd9:    return "DDDDCDD";
            4'd10:   return "DDCDCDD";
            4'd11:   return "DDCDCDC";
            4'd12:   return "DDCDDDC";
            default: return "DDCDDDD";
        endcase
    endfunction

    // Letter k of the 99-symbol word for the frame being played
    function automatic byte word_letter(input int k);
        string      s;
        logic [3:0] t;
        t = (p_tidx < irac_pkg::NUM_TEMPS) ? p_tidx : 4'd0;
        if (k < 35)
            return seq_head[k];
        if (k < 40)
            return p_off ? seq_b_off[k - 35] : seq_b_on[k - 35];
        if (k < 45)
            return seq_c[k - 40];
        if (k < 54)
            return p_off ? seq_d_off[k - 45] : seq_d_on[k - 45];
        if (k < 60)
            return L_SHORT;
        if (k < 74)
        begin
            if (p_off)
                return seq_e_off[k - 60];
            if (k < 67)
                return L_SHORT;
            s = first_slot_seq(t);
            return s[k - 67];
        end
        if (k < 83)
            return L_SHORT;
        if (k < 90)
        begin
            if (p_off)
                return seq_f_off[k - 83];
            s = second_slot_seq(t);
            return s[k - 83];
        end
        if (k < irac_pkg::WORD_LEN)
            return seq_tail[k - 90];
        return L_SHORT;
    endfunction

    // Programmed length of the symbol at a frame position
    function automatic logic [15:0] position_len(input logic [7:0] pos);
        byte c;
        if (pos < irac_pkg::WORD_LEN)
            c = word_letter(int'(pos));
        else if (pos == irac_pkg::WORD_LEN)
            c = L_GAP;
        else
            c = word_letter(int'(pos) - int'(irac_pkg::WORD_LEN) - 1);
        case (c)
            L_GAP:   return sym_len[CFG_GAP];
            L_HEAD:  return sym_len[CFG_HEADER];
            L_LONG:  return sym_len[CFG_LONG];
            default: return sym_len[CFG_SHORT];
        endcase
    endfunction

    // Load the current symbol, skip zero lengths, record the setting at frame end
    function automatic void load_symbol_len();
        while (p_sending)
        begin
            if (p_pos >= irac_pkg::FRAME_SYMBOLS)
            begin
                p_sending = 1'b0;
                p_left    = 16'd0;
                p_stored[p_emit] = p_off ? 5'd0 : 5'(p_tidx + irac_pkg::MIN_TEMP);
                n_frames++;
                return;
            end
            p_left = position_len(p_pos);
            if (p_left != 16'd0)
                return;
            p_pos++;
        end
    endfunction

    // Advance the mirrored frame player by one item and form its report
    function automatic report_t frame_report(input logic act, input logic [6:0] temp,
                                             input logic em, input logic run);
        report_t r;
        logic    in_range;
        logic    mark;
        r = '0;
        if (act == ACT_SEND)
        begin
            in_range = (temp == 7'd0) ||
                       (temp >= irac_pkg::MIN_TEMP && temp <= irac_pkg::MAX_TEMP);
            if (!p_sending && in_range)
            begin
                r.accepted = 1'b1;
                p_sending  = 1'b1;
                p_off      = (temp == 7'd0);
                p_tidx     = p_off ? 4'd0 : 4'(temp - irac_pkg::MIN_TEMP);
                p_emit     = em;
                p_pos      = 8'd0;
                n_started++;
                load_symbol_len();
            end
        end
        else if (p_sending)
        begin
            if (p_left > 16'd1)
                p_left--;
            else
            begin
                p_pos++;
                load_symbol_len();
            end
        end
        mark       = p_sending && !p_pos[0];
        r.mark_a   = mark && (p_emit == 1'b0);
        r.mark_b   = mark && (p_emit == 1'b1);
        r.busy     = p_sending;
        if (!run)
            r.setting = SET_OFF;
        else if (p_stored[em] != 5'd0)
            r.setting = $signed({1'b0, p_stored[em]});
        else
            r.setting = SET_UNKNOWN;
        return r;
    endfunction

    function automatic void cmp_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            n_errors++;
        end
    endfunction

    // Receiver: stall on a repeating pattern set per phase
    always @(posedge clk)
    begin
        m_tready <= rst_n ? rx_pattern[rx_tick] : 1'b0;
        rx_tick  <= rx_tick + 4'd1;
    end

    // Score results, predict accepted items, track register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_recv++;
                got_rep.mark_a   = m_tdata[0];
                got_rep.mark_b   = m_tdata[1];
                got_rep.busy     = m_tdata[2];
                got_rep.accepted = m_tdata[3];
                got_rep.setting  = m_tdata[9:4];
                if (due_reports.size() == 0)
                begin
                    $error("result transfer with no expected result pending");
                    n_errors++;
                end
                else
                begin
                    want_rep = due_reports.pop_front();
                    cmp_field("carrier_enable_a", want_rep.mark_a, got_rep.mark_a);
                    cmp_field("carrier_enable_b", want_rep.mark_b, got_rep.mark_b);
                    cmp_field("busy_res", want_rep.busy, got_rep.busy);
                    cmp_field("command_accepted", want_rep.accepted, got_rep.accepted);
                    cmp_field("reported_setting", want_rep.setting, got_rep.setting);
                end
            end
            if (s_tvalid && s_tready)
            begin
                fx_rep   = fixed_reports.pop_front();
                pred_rep = frame_report(s_tuser, s_tdata[6:0], s_tdata[7], s_tdata[8]);
                due_reports.push_back(fx_rep.typed ? fx_rep.want : pred_rep);
            end
            if (cfg_valid && cfg_ready)
                sym_len[cfg_addr] = cfg_data;
        end
    end

    // Watchdog: end the run after a long stretch with no transfer at all
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one item, in bursts with random gaps, and hold it until transferred
    task automatic drive_item(input logic act, input logic [6:0] temp, input logic em,
                              input logic run, input logic typed, input report_t want);
        int     gap;
        fixed_t fx;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!tx_steady)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        cfg_valid <= 1'b0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fx.typed = typed;
        fx.want  = want;
        fixed_reports.push_back(fx);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, run, em, temp};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
    endtask

    // Hold the sender until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (n_recv != n_sent)
            @(posedge clk);
    endtask

    task automatic write_len(input irac_pkg::cfg_addr_t a, input logic [15:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_addr  <= a;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        n_cfg++;
    endtask

    // Tick until the frame in flight has been played out
    task automatic flush_frame();
        while (p_sending)
            drive_item(ACT_TICK, 7'($urandom()), 1'($urandom()), 1'($urandom()), 1'b0, '0);
    endtask

    initial
    begin
        report_t  want;
        int       pick;
        logic [6:0] temp;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 16'd0;
        s_tuser    = ACT_TICK;
        cfg_valid  = 1'b0;
        cfg_addr   = CFG_GAP;
        cfg_data   = 16'd0;
        rx_tick    = 4'd0;
        rx_pattern = 16'hFFFF;
        n_sent     = 0;
        n_recv     = 0;
        n_errors   = 0;
        n_started  = 0;
        n_frames   = 0;
        n_cfg      = 0;
        burst_left = 0;
        tx_steady  = 1'b0;
        sym_len[CFG_GAP]    = 16'd5300;
        sym_len[CFG_HEADER] = 16'd4400;
        sym_len[CFG_LONG]   = 16'd1660;
        sym_len[CFG_SHORT]  = 16'd550;
        p_sending   = 1'b0;
        p_pos       = 8'd0;
        p_left      = 16'd0;
        p_off       = 1'b0;
        p_tidx      = 4'd0;
        p_emit      = 1'b0;
        p_stored[0] = 5'd0;
        p_stored[1] = 5'd0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows
        rx_pattern = 16'hB6DB;
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CFG)
                write_len(dir_table[i].addr, dir_table[i].val);
            else
            begin
                want          = '0;
                want.busy     = dir_table[i].w_busy;
                want.accepted = dir_table[i].w_acc;
                want.setting  = dir_table[i].w_set;
                drive_item(dir_table[i].act, dir_table[i].temp, dir_table[i].em,
                           dir_table[i].run, dir_table[i].typed, want);
            end
        end

        // Zero the word symbols mid-frame: the rest of the frame collapses to the gap
        write_len(CFG_HEADER, 16'd0);
        write_len(CFG_LONG, 16'd0);
        write_len(CFG_SHORT, 16'd0);
        flush_frame();

        // Long gap with every other symbol skipped: one long pause, then done at once
        write_len(CFG_GAP, 16'd150);
        tx_steady  = 1'b1;
        rx_pattern = 16'hFFFF;
        drive_item(ACT_SEND, 7'd21, 1'b0, 1'b1, 1'b0, '0);
        flush_frame();
        write_len(CFG_HEADER, 16'hFFFF);
        write_len(CFG_LONG, 16'hFFFF);
        write_len(CFG_SHORT, 16'hFFFF);

        // Random phases: short symbol lengths so that frames complete often
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            for (int r = 0; r < 4; r++)
                write_len(irac_pkg::cfg_addr_t'(r),
                          ($urandom_range(0, 9) < 4) ? 16'd0 : 16'($urandom_range(1, 2)));
            tx_steady  = ($urandom_range(0, 3) == 0);
            rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
            repeat (ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 3)
                        temp = 7'd0;
                    else if (pick < 12)
                        temp = 7'($urandom_range(17, 30));
                    else
                        temp = 7'($urandom_range(0, 127));
                    drive_item(ACT_SEND, temp, 1'($urandom()), 1'($urandom()), 1'b0, '0);
                end
                else
                    drive_item(ACT_TICK, 7'($urandom()), 1'($urandom()), 1'($urandom()),
                               1'b0, '0);
            end
        end

        // Drain, then wait for any stray result
        wait_idle();
        cfg_valid <= 1'b0;
        repeat (8) @(posedge clk);
        if (due_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", due_reports.size());
            n_errors++;
        end

        $display("Covered %0d items, %0d frames started and %0d completed on both emitters,",
                 n_sent, n_started, n_frames);
        $display("with %0d length writes, from zero-length skipping to a long gap symbol.",
                 n_cfg);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/irac_pkg.sv
hdl/irac_symbol_decode.sv
hdl/ir_aircon_frame_sender_top.sv
verif/tb_top.sv
